>>> rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types, widths and codes of the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 17;
    localparam int SUM_W  = 18;

    localparam logic [LEN_W-1:0] POOL_BYTES = 17'd65536;
    localparam int MAX_FREE_DEF = 16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_LIST_FULL = 2'd2,
        STAT_BAD_FREE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_CMP,
        S_BUMP,
        S_FDEC,
        S_SH_RD,
        S_SH_WR,
        S_INS,
        S_DONE
    } state_t;

    // one free range, end is exclusive
    typedef struct packed {
        logic [LEN_W-1:0] rng_end;
        logic [LEN_W-1:0] rng_start;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } res_t;

endpackage

>>> rtl/first_fit_range_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit allocator over a byte pool with a sorted, coalescing free list.
// ----------------------------------------------------------------------------
// One request is worked at a time by a sequencer around a shared adder and
// comparator and a free-list RAM with registered reads. A request's time grows
// with the free entries scanned, each one read and then compared, and with the
// entries moved, each one read and then written, when the list opens or closes
// a slot, and it ends with a final update; the registered free-list reads set
// this pace. The result sits in an output register, so the next item is taken
// while it waits.
module first_fit_range_allocator #(
    parameter int MAX_FREE = ffra_pkg::MAX_FREE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[15:0], size[32:16], zero pad
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // granted_address[15:0], status[17:16], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    logic           res_valid;
    logic           res_ready;
    ffra_pkg::res_t res;
    logic           m_tvalid_reg;
    logic [23:0]    m_tdata_reg;

    ffra_ctrl #(
        .MAX_FREE (MAX_FREE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_address (s_tdata[15:0]),
        .in_size    (s_tdata[32:16]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_tdata_reg <= {6'd0, res.status, res.addr};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ffra_alu.sv
// ----------------------------------------------------------------------------
// ffra_alu
// Shared adder and comparator used by every scan step.
// ----------------------------------------------------------------------------
module ffra_alu (
    input  logic [ffra_pkg::SUM_W-1:0] x,
    input  logic [ffra_pkg::SUM_W-1:0] y,
    input  logic [ffra_pkg::SUM_W-1:0] z,
    output logic [ffra_pkg::SUM_W-1:0] sum,
    output logic                       eq,
    output logic                       lt
);

    assign sum = x + y;
    assign eq  = (sum == z);
    assign lt  = (sum < z);

endmodule

>>> rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer of the allocator: scans the free list, shifts entries, keeps top.
// ----------------------------------------------------------------------------
module ffra_ctrl #(
    parameter int MAX_FREE = ffra_pkg::MAX_FREE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_cmd,
    input  logic [ffra_pkg::ADDR_W-1:0] in_address,
    input  logic [ffra_pkg::LEN_W-1:0]  in_size,
    input  logic                        cfg_valid,
    input  logic [ffra_pkg::LEN_W-1:0]  cfg_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output ffra_pkg::res_t              res
);

    localparam int IW = $clog2(MAX_FREE);
    localparam int CW = $clog2(MAX_FREE + 1);
    localparam int EW = $bits(ffra_pkg::entry_t);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_FREE);

    ffra_pkg::state_t state_reg, state_next;

    logic                        cmd_reg, cmd_next;
    logic [ffra_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ffra_pkg::LEN_W-1:0]  size_reg, size_next;
    logic [ffra_pkg::SUM_W-1:0]  e_reg, e_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [CW-1:0]               src_reg, src_next;
    logic                        up_reg, up_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [ffra_pkg::LEN_W-1:0]  top_reg, top_next;
    logic [ffra_pkg::LEN_W-1:0]  limit_reg;
    ffra_pkg::entry_t            prev_reg, prev_next;
    ffra_pkg::entry_t            cur_reg, cur_next;
    ffra_pkg::res_t              res_reg, res_next;

    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    ffra_pkg::entry_t            ram_wdata;
    logic [IW-1:0]               ram_raddr;
    logic [EW-1:0]               ram_rdata;
    ffra_pkg::entry_t            ent;

    logic [ffra_pkg::SUM_W-1:0]  alu_x, alu_y, alu_z, alu_sum;
    logic                        alu_eq, alu_lt;

    logic [CW-1:0]               idx_inc, idx_dec, src_inc, src_dec;
    logic                        last_scan, has_prev, at_end, full;
    logic                        ovl_prev, ovl_next, join_prev, join_next, e_top;
    logic [ffra_pkg::SUM_W-1:0]  a18, bump_sum;
    logic [ffra_pkg::LEN_W-1:0]  limit_eff;
    logic                        bump_fail, is_free;

    ffra_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FREE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffra_alu u_alu (
        .x   (alu_x),
        .y   (alu_y),
        .z   (alu_z),
        .sum (alu_sum),
        .eq  (alu_eq),
        .lt  (alu_lt)
    );

    assign ent     = ffra_pkg::entry_t'(ram_rdata);
    assign is_free = (cmd_reg == ffra_pkg::CMD_FREE);
    assign a18     = {2'b00, addr_reg};

    // free: a < start ends the scan; alloc: start + size against end
    assign alu_x = is_free ? a18 : {1'b0, ent.rng_start};
    assign alu_y = is_free ? '0 : {1'b0, size_reg};
    assign alu_z = is_free ? {1'b0, ent.rng_start} : {1'b0, ent.rng_end};

    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign src_inc   = src_reg + 1'b1;
    assign src_dec   = src_reg - 1'b1;
    assign last_scan = (idx_inc == cnt_reg);
    assign has_prev  = (idx_reg != '0);
    assign at_end    = (idx_reg == cnt_reg);
    assign full      = (cnt_reg == FULL_CNT);
    assign ovl_prev  = has_prev && ({1'b0, prev_reg.rng_end} > a18);
    assign ovl_next  = !at_end && ({1'b0, cur_reg.rng_start} < e_reg);
    assign join_prev = has_prev && ({1'b0, prev_reg.rng_end} == a18);
    assign join_next = !at_end && ({1'b0, cur_reg.rng_start} == e_reg);
    assign e_top     = (e_reg == {1'b0, top_reg});
    assign limit_eff = (limit_reg < ffra_pkg::POOL_BYTES) ? limit_reg : ffra_pkg::POOL_BYTES;
    assign bump_sum  = {1'b0, top_reg} + {1'b0, size_reg};
    assign bump_fail = (bump_sum > {1'b0, limit_eff});

    assign ram_raddr = (state_reg == ffra_pkg::S_SH_RD) ? src_reg[IW-1:0] : idx_reg[IW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ffra_pkg::S_START;
                end
            end
            ffra_pkg::S_START:
            begin
                if (size_reg == '0)
                begin
                    state_next = ffra_pkg::S_DONE;
                end
                else if (!is_free)
                begin
                    state_next = (cnt_reg == '0) ? ffra_pkg::S_BUMP : ffra_pkg::S_RD;
                end
                else if (e_reg > {1'b0, top_reg})
                begin
                    state_next = ffra_pkg::S_DONE;
                end
                else
                begin
                    state_next = (cnt_reg == '0) ? ffra_pkg::S_FDEC : ffra_pkg::S_RD;
                end
            end
            ffra_pkg::S_RD:
            begin
                state_next = ffra_pkg::S_CMP;
            end
            ffra_pkg::S_CMP:
            begin
                if (!is_free)
                begin
                    if (alu_eq)
                    begin
                        state_next = (idx_inc < cnt_reg) ? ffra_pkg::S_SH_RD : ffra_pkg::S_DONE;
                    end
                    else if (alu_lt)
                    begin
                        state_next = ffra_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = last_scan ? ffra_pkg::S_BUMP : ffra_pkg::S_RD;
                    end
                end
                else
                begin
                    state_next = (alu_lt || last_scan) ? ffra_pkg::S_FDEC : ffra_pkg::S_RD;
                end
            end
            ffra_pkg::S_BUMP:
            begin
                state_next = ffra_pkg::S_DONE;
            end
            ffra_pkg::S_FDEC:
            begin
                if (ovl_prev || ovl_next || at_end)
                begin
                    state_next = ffra_pkg::S_DONE;
                end
                else if (join_prev && join_next)
                begin
                    state_next = (idx_inc < cnt_reg) ? ffra_pkg::S_SH_RD : ffra_pkg::S_DONE;
                end
                else if (join_prev || join_next || full)
                begin
                    state_next = ffra_pkg::S_DONE;
                end
                else
                begin
                    state_next = ffra_pkg::S_SH_RD;
                end
            end
            ffra_pkg::S_SH_RD:
            begin
                state_next = ffra_pkg::S_SH_WR;
            end
            ffra_pkg::S_SH_WR:
            begin
                if (up_reg)
                begin
                    state_next = (src_reg == idx_reg) ? ffra_pkg::S_INS : ffra_pkg::S_SH_RD;
                end
                else
                begin
                    state_next = (src_inc < cnt_reg) ? ffra_pkg::S_SH_RD : ffra_pkg::S_DONE;
                end
            end
            ffra_pkg::S_INS:
            begin
                state_next = ffra_pkg::S_DONE;
            end
            ffra_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffra_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cmd_next  = cmd_reg;
        addr_next = addr_reg;
        size_next = size_reg;
        e_next    = e_reg;
        idx_next  = idx_reg;
        src_next  = src_reg;
        up_next   = up_reg;
        cnt_next  = cnt_reg;
        top_next  = top_reg;
        prev_next = prev_reg;
        cur_next  = cur_reg;
        res_next  = res_reg;
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IW-1:0];
        ram_wdata = ent;
        unique case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = in_cmd;
                    addr_next = in_address;
                    size_next = in_size;
                    e_next    = {2'b00, in_address} + {1'b0, in_size};
                    idx_next  = '0;
                    res_next  = '{addr: '0, status: ffra_pkg::STAT_OK};
                end
            end
            ffra_pkg::S_START:
            begin
                if (size_reg != '0 && is_free && e_reg > {1'b0, top_reg})
                begin
                    res_next.status = ffra_pkg::STAT_BAD_FREE;
                end
            end
            ffra_pkg::S_CMP:
            begin
                if (!is_free)
                begin
                    if (alu_eq)
                    begin
                        res_next.addr = ent.rng_start[ffra_pkg::ADDR_W-1:0];
                        src_next      = idx_inc;
                        up_next       = 1'b0;
                        if (!(idx_inc < cnt_reg))
                        begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    else if (alu_lt)
                    begin
                        res_next.addr       = ent.rng_start[ffra_pkg::ADDR_W-1:0];
                        ram_we              = 1'b1;
                        ram_wdata.rng_start = alu_sum[ffra_pkg::LEN_W-1:0];
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                else if (alu_lt)
                begin
                    cur_next = ent;
                end
                else
                begin
                    prev_next = ent;
                    idx_next  = idx_inc;
                end
            end
            ffra_pkg::S_BUMP:
            begin
                if (bump_fail)
                begin
                    res_next.status = ffra_pkg::STAT_NO_SPACE;
                end
                else
                begin
                    res_next.addr = top_reg[ffra_pkg::ADDR_W-1:0];
                    top_next      = bump_sum[ffra_pkg::LEN_W-1:0];
                end
            end
            ffra_pkg::S_FDEC:
            begin
                if (ovl_prev || ovl_next)
                begin
                    res_next.status = ffra_pkg::STAT_BAD_FREE;
                end
                else if (at_end)
                begin
                    if (e_top)
                    begin
                        // freeing the tail; a free range ending there goes too
                        if (join_prev)
                        begin
                            top_next = prev_reg.rng_start;
                            cnt_next = cnt_reg - 1'b1;
                        end
                        else
                        begin
                            top_next = {1'b0, addr_reg};
                        end
                    end
                    else if (join_prev)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_dec[IW-1:0];
                        ram_wdata = '{rng_end: e_reg[ffra_pkg::LEN_W-1:0],
                                      rng_start: prev_reg.rng_start};
                    end
                    else if (full)
                    begin
                        res_next.status = ffra_pkg::STAT_LIST_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[IW-1:0];
                        ram_wdata = '{rng_end: e_reg[ffra_pkg::LEN_W-1:0],
                                      rng_start: {1'b0, addr_reg}};
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                else if (join_prev)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_dec[IW-1:0];
                    if (join_next)
                    begin
                        ram_wdata = '{rng_end: cur_reg.rng_end, rng_start: prev_reg.rng_start};
                        src_next  = idx_inc;
                        up_next   = 1'b0;
                        if (!(idx_inc < cnt_reg))
                        begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        ram_wdata = '{rng_end: e_reg[ffra_pkg::LEN_W-1:0],
                                      rng_start: prev_reg.rng_start};
                    end
                end
                else if (join_next)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{rng_end: cur_reg.rng_end, rng_start: {1'b0, addr_reg}};
                end
                else if (full)
                begin
                    res_next.status = ffra_pkg::STAT_LIST_FULL;
                end
                else
                begin
                    src_next = cnt_reg - 1'b1;
                    up_next  = 1'b1;
                end
            end
            ffra_pkg::S_SH_WR:
            begin
                ram_we = 1'b1;
                if (up_reg)
                begin
                    ram_waddr = src_inc[IW-1:0];
                    if (src_reg != idx_reg)
                    begin
                        src_next = src_dec;
                    end
                end
                else
                begin
                    ram_waddr = src_dec[IW-1:0];
                    src_next  = src_inc;
                    if (!(src_inc < cnt_reg))
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ffra_pkg::S_INS:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{rng_end: e_reg[ffra_pkg::LEN_W-1:0],
                              rng_start: {1'b0, addr_reg}};
                cnt_next  = cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffra_pkg::S_IDLE;
            cnt_reg   <= '0;
            top_reg   <= '0;
            limit_reg <= ffra_pkg::POOL_BYTES;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        addr_reg <= addr_next;
        size_reg <= size_next;
        e_reg    <= e_next;
        idx_reg  <= idx_next;
        src_reg  <= src_next;
        up_reg   <= up_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
    end

    assign in_ready  = (state_reg == ffra_pkg::S_IDLE);
    assign res_valid = (state_reg == ffra_pkg::S_DONE);
    assign res       = res_reg;

endmodule
